/* design/sda_pkg.sv */
package sda_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] a_mantissa;
    logic signed [7:0]  a_exponent;
    logic signed [63:0] b_mantissa;
    logic signed [7:0]  b_exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_mantissa;
    logic signed [7:0]  result_exponent;
    logic [2:0]         error;
  } out_item_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NO_COMMON = 3'd1;
  localparam logic [2:0] ERR_EXP_OVER  = 3'd2;
  localparam logic [2:0] ERR_EXP_UNDER = 3'd3;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd4;
  localparam logic [2:0] ERR_DIV_OVER  = 3'd5;
  localparam logic [2:0] ERR_MAX       = ERR_DIV_OVER;

  // Largest magnitude that may still be multiplied by ten without overflow.
  localparam logic signed [63:0] FIT_MAX = 64'sd922337203685477580;
  localparam logic signed [63:0] MANT_MIN = {1'b1, 63'd0};

endpackage

/* design/scaled_decimal_alu.sv */
// Scaled decimal arithmetic unit. Each operand is a signed 64-bit mantissa
// times ten to a signed 8-bit exponent, and the op field selects add,
// subtract, multiply or divide. One item is worked at a time: in_ready is
// high only while the sequencer is idle, and a finished result waits in the
// output register while the next item is accepted. The time an item takes
// is set by the shared times-ten adder (one decimal scaling step at a time,
// up to 255 steps when a zero dividend is scaled down), the divide-by-ten
// unit (one pass per trailing zero stripped, one exponent step at a time
// once the mantissa is zero), the restoring divider for divide and three
// passes through one 32 by 32 multiplier for multiply. When error is
// nonzero the mantissa and exponent of the result are zero.
module scaled_decimal_alu
  import sda_pkg::*;
#(
  parameter int EXPONENT_LIMIT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Exponents are carried in ten bits so that sums and differences of two
  // 8-bit exponents never wrap.
  localparam logic signed [9:0] ELIM  = 10'(EXPONENT_LIMIT);
  localparam logic signed [9:0] NELIM = -10'(EXPONENT_LIMIT);
  localparam logic signed [9:0] EMIN  = -10'sd128;
  localparam logic signed [9:0] EMAX  = 10'sd127;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCALE, S_ADDSUB, S_MUL0, S_MUL1, S_MUL2,
    S_DSCALE, S_DIV, S_NORM, S_D10, S_NCHK, S_NUP, S_NDOWN, S_DONE
  } state_t;

  state_t             state_r;
  logic [1:0]         op_r;
  logic signed [63:0] am_r, bm_r;
  logic signed [9:0]  ae_r, be_r;
  logic signed [63:0] m_r;
  logic signed [9:0]  e_r, tgt_r;
  logic [2:0]         err_r;
  logic               swap_r, strict_r;
  logic [31:0]        acc_r;
  // Restoring divider.
  logic [63:0]        rem_r, quo_r, dv_r;
  logic [6:0]         cnt_r;
  logic               neg_r;
  // Divide-by-ten unit and its return mode (set when bringing a low exponent up).
  logic [63:0]        n_r, q_r, t_r;
  logic [3:0]         dstep_r;
  logic               down_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic               fits;
  logic signed [63:0] m_x10;
  logic [31:0]        mul_x, mul_y;
  logic [63:0]        mul_p;
  logic [64:0]        trial;
  logic [63:0]        q_fix;
  logic               r_zero;
  logic signed [9:0]  ein_a, ein_b, dsub;

  assign fits  = (m_r <= FIT_MAX) && (m_r >= -FIT_MAX);
  assign m_x10 = (m_r <<< 3) + (m_r <<< 1);
  assign ein_a = {{2{in_data.a_exponent[7]}}, in_data.a_exponent};
  assign ein_b = {{2{in_data.b_exponent[7]}}, in_data.b_exponent};
  assign dsub  = e_r - be_r;

  // The one multiplier, fed one 32-bit half pair per multiply state.
  always_comb begin
    mul_x = am_r[31:0];
    mul_y = bm_r[31:0];
    case (state_r)
      S_MUL1: mul_y = bm_r[63:32];
      S_MUL2: mul_x = am_r[63:32];
      default: ;
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign trial = {rem_r, quo_r[63]} - {1'b0, dv_r};

  // The reciprocal estimate leaves a remainder below twenty in t_r.
  assign q_fix  = (t_r > 64'd9) ? q_r + 64'd1 : q_r;
  assign r_zero = (t_r == 64'd0) || (t_r == 64'd10);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the valid flag is handled by the state itself.
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.op;
            am_r    <= in_data.a_mantissa;
            bm_r    <= in_data.b_mantissa;
            ae_r    <= ein_a;
            be_r    <= ein_b;
            err_r   <= ERR_OK;
            down_r  <= 1'b0;
            state_r <= S_START;
          end
        end
        S_START: begin
          case (op_r)
            OP_ADD, OP_SUB: begin
              // The operand with the larger exponent is scaled down to the other.
              if (be_r < ae_r) begin
                m_r <= am_r; e_r <= ae_r; tgt_r <= be_r; swap_r <= 1'b0;
              end else begin
                m_r <= bm_r; e_r <= be_r; tgt_r <= ae_r; swap_r <= 1'b1;
              end
              state_r <= S_SCALE;
            end
            OP_MUL: begin
              if ((ae_r + be_r) > ELIM) begin
                err_r <= ERR_EXP_OVER; state_r <= S_DONE;
              end else if ((ae_r + be_r) < NELIM) begin
                err_r <= ERR_EXP_UNDER; state_r <= S_DONE;
              end else begin
                e_r <= ae_r + be_r; state_r <= S_MUL0;
              end
            end
            default: begin
              if (bm_r == 64'sd0) begin
                err_r <= ERR_DIV_ZERO; state_r <= S_DONE;
              end else begin
                m_r <= am_r; e_r <= ae_r; state_r <= S_DSCALE;
              end
            end
          endcase
        end
        S_SCALE: begin
          if (e_r > tgt_r && fits) begin
            m_r <= m_x10; e_r <= e_r - 10'sd1;
          end else if (e_r == tgt_r) begin
            state_r <= S_ADDSUB;
          end else begin
            err_r <= ERR_NO_COMMON; state_r <= S_DONE;
          end
        end
        S_ADDSUB: begin
          if (op_r == OP_ADD) m_r <= m_r + (swap_r ? am_r : bm_r);
          else if (swap_r)    m_r <= am_r - m_r;
          else                m_r <= m_r - bm_r;
          strict_r <= 1'b1;
          state_r  <= S_NORM;
        end
        S_MUL0: begin
          m_r <= mul_p; state_r <= S_MUL1;
        end
        S_MUL1: begin
          acc_r <= mul_p[31:0]; state_r <= S_MUL2;
        end
        S_MUL2: begin
          m_r      <= m_r + {acc_r + mul_p[31:0], 32'd0};
          strict_r <= 1'b1;
          state_r  <= S_NORM;
        end
        S_DSCALE: begin
          if (e_r > EMIN && fits) begin
            m_r <= m_x10; e_r <= e_r - 10'sd1;
          end else if (dsub > EMAX || dsub < EMIN) begin
            err_r <= ERR_EXP_OVER; state_r <= S_DONE;
          end else if (m_r == MANT_MIN && bm_r == -64'sd1) begin
            err_r <= ERR_DIV_OVER; state_r <= S_DONE;
          end else begin
            e_r     <= dsub;
            rem_r   <= 64'd0;
            quo_r   <= mag(m_r);
            dv_r    <= mag(bm_r);
            neg_r   <= m_r[63] ^ bm_r[63];
            cnt_r   <= 7'd64;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], quo_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            m_r      <= neg_r ? -$signed({quo_r[62:0], ~trial[64]})
                              :  $signed({quo_r[62:0], ~trial[64]});
            strict_r <= 1'b0;
            state_r  <= S_NORM;
          end
        end
        S_NORM: begin
          // Strip one trailing zero per pass through the divide-by-ten unit.
          if (m_r != 64'sd0 && e_r < ELIM) begin
            n_r     <= mag(m_r);
            neg_r   <= m_r[63];
            dstep_r <= 4'd0;
            down_r  <= 1'b0;
            state_r <= S_D10;
          end else begin
            state_r <= S_NCHK;
          end
        end
        S_D10: begin
          dstep_r <= dstep_r + 4'd1;
          case (dstep_r)
            4'd0: q_r <= (n_r >> 1) + (n_r >> 2);
            4'd1: q_r <= q_r + (q_r >> 4);
            4'd2: q_r <= q_r + (q_r >> 8);
            4'd3: q_r <= q_r + (q_r >> 16);
            4'd4: q_r <= q_r + (q_r >> 32);
            4'd5: q_r <= q_r >> 3;
            4'd6: t_r <= (q_r << 3) + (q_r << 1);
            4'd7: t_r <= n_r - t_r;
            default: begin
              if (down_r) begin
                m_r     <= neg_r ? -$signed(q_fix) : $signed(q_fix);
                e_r     <= e_r + 10'sd1;
                state_r <= S_NDOWN;
              end else if (r_zero) begin
                m_r     <= neg_r ? -$signed(q_fix) : $signed(q_fix);
                e_r     <= e_r + 10'sd1;
                state_r <= S_NORM;
              end else begin
                state_r <= S_NCHK;
              end
            end
          endcase
        end
        S_NCHK: begin
          if (e_r > ELIM) begin
            if (strict_r) begin
              err_r <= ERR_EXP_OVER; state_r <= S_DONE;
            end else begin
              state_r <= S_NUP;
            end
          end else if (e_r < NELIM) begin
            if (strict_r) begin
              err_r <= ERR_EXP_UNDER; state_r <= S_DONE;
            end else begin
              state_r <= S_NDOWN;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_NUP: begin
          if (e_r > ELIM && fits) begin
            m_r <= m_x10; e_r <= e_r - 10'sd1;
          end else begin
            if (e_r > ELIM) err_r <= ERR_EXP_OVER;
            state_r <= S_DONE;
          end
        end
        S_NDOWN: begin
          if (e_r < NELIM) begin
            if (m_r == 64'sd0) begin
              e_r <= e_r + 10'sd1;
            end else begin
              n_r     <= mag(m_r);
              neg_r   <= m_r[63];
              dstep_r <= 4'd0;
              down_r  <= 1'b1;
              state_r <= S_D10;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r.error <= err_r;
            if (err_r != ERR_OK) begin
              out_data_r.result_mantissa <= 64'sd0;
              out_data_r.result_exponent <= 8'sd0;
            end else begin
              out_data_r.result_mantissa <= m_r;
              out_data_r.result_exponent <= e_r[7:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/sda_checker.sv */
module sda_checker
  import sda_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // One item at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error != ERR_OK |->
      out_data.result_mantissa == 64'sd0 && out_data.result_exponent == 8'sd0)
    else $error("error result with nonzero fields");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error <= ERR_MAX)
    else $error("undefined error code");

endmodule

bind scaled_decimal_alu sda_checker u_sda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/scaled_decimal_alu_test.sv */
`timescale 1ns / 1ps

module scaled_decimal_alu_test;
  import sda_pkg::*;

  localparam int EXP_LIMIT = 64;
  localparam int RANDOM_ITEMS = 1750;
  localparam longint MAX_CYCLES = 3000000;
  localparam logic signed [63:0] MANT_MAX = 64'sh7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  // Each phase sets how often the sender and the receiver take a break.
  // Phase 0: sender idles 36%, receiver 54%; phase 1 swaps them; phase 2
  // runs both sides flat out.
  int phase = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 54;

  // Operand items waiting to be offered, and the results they should produce.
  in_item_t pending_ops[$];
  out_item_t expected_results[$];
  int failures = 0;
  longint cycle_count = 0;
  int items_sent = 0;
  bit stimulus_done = 1'b0;

  // A long stretch in which the receiver holds off while the sender keeps
  // offering items, so the input side backs up.
  int hold_off_left = 0;
  bit hold_off_done = 1'b0;

  scaled_decimal_alu #(.EXPONENT_LIMIT(EXP_LIMIT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic bit fits_ten(logic signed [63:0] m);
    return m <= FIT_MAX && m >= -FIT_MAX;
  endfunction

  // Strip trailing zeros and check the exponent range. Divide uses the
  // lenient form, which rescales instead of failing where it can.
  function automatic logic [2:0] normalize_decimal(ref logic signed [63:0] m,
                                                   ref int e, input bit strict);
    while (m != 0 && m % 10 == 0 && e < EXP_LIMIT) begin
      m = m / 10;
      e = e + 1;
    end
    if (e > EXP_LIMIT) begin
      if (strict) return ERR_EXP_OVER;
      while (e > EXP_LIMIT && fits_ten(m)) begin
        m = m * 10;
        e = e - 1;
      end
      if (e > EXP_LIMIT) return ERR_EXP_OVER;
    end
    if (e < -EXP_LIMIT) begin
      if (strict) return ERR_EXP_UNDER;
      while (e < -EXP_LIMIT) begin
        m = m / 10;
        e = e + 1;
      end
    end
    return ERR_OK;
  endfunction

  // Computes the decimal result for one operand item.
  function automatic out_item_t decimal_result(in_item_t it);
    out_item_t r;
    logic signed [63:0] m;
    logic signed [63:0] other;
    int e;
    int target;
    int d;
    logic [2:0] err;
    m = 0;
    e = 0;
    err = ERR_OK;
    case (it.op)
      OP_ADD, OP_SUB: begin
        // Bring the larger-exponent operand down to the smaller exponent.
        if (it.b_exponent < it.a_exponent) begin
          m = it.a_mantissa;
          e = it.a_exponent;
          target = it.b_exponent;
          other = it.b_mantissa;
        end else begin
          m = it.b_mantissa;
          e = it.b_exponent;
          target = it.a_exponent;
          other = it.a_mantissa;
        end
        while (e > target && fits_ten(m)) begin
          e = e - 1;
          m = m * 10;
        end
        if (e != target) err = ERR_NO_COMMON;
        else if (it.op == OP_ADD) m = m + other;
        else if (it.b_exponent < it.a_exponent) m = m - other;
        else m = other - m;
        if (err == ERR_OK) err = normalize_decimal(m, e, 1'b1);
      end
      OP_MUL: begin
        e = int'(it.a_exponent) + int'(it.b_exponent);
        if (e > EXP_LIMIT) err = ERR_EXP_OVER;
        else if (e < -EXP_LIMIT) err = ERR_EXP_UNDER;
        else begin
          m = it.a_mantissa * it.b_mantissa;
          err = normalize_decimal(m, e, 1'b1);
        end
      end
      default: begin
        if (it.b_mantissa == 0) err = ERR_DIV_ZERO;
        else begin
          // Scale the dividend up as far as it fits before dividing.
          m = it.a_mantissa;
          e = it.a_exponent;
          while (e > -128 && fits_ten(m)) begin
            e = e - 1;
            m = m * 10;
          end
          d = e - int'(it.b_exponent);
          if (d > 127 || d < -128) err = ERR_EXP_OVER;
          else if (m == MANT_MIN && it.b_mantissa == -64'sd1) err = ERR_DIV_OVER;
          else begin
            e = d;
            m = m / it.b_mantissa;
            err = normalize_decimal(m, e, 1'b0);
          end
        end
      end
    endcase
    if (err != ERR_OK) begin
      m = 0;
      e = 0;
    end
    r.result_mantissa = m;
    r.result_exponent = e[7:0];
    r.error = err;
    return r;
  endfunction

  function automatic logic signed [63:0] rand_mantissa();
    logic signed [63:0] m;
    case ($urandom_range(0, 5))
      0: m = {$urandom, $urandom};
      1: m = $signed(64'($urandom_range(0, 2000))) - 1000;
      2: m = $signed(64'($urandom_range(1, 99))) * 64'sd1000000;
      3: m = $urandom_range(0, 1) ? MANT_MAX - $urandom_range(0, 3)
                                  : MANT_MIN + $urandom_range(0, 3);
      4: m = $urandom_range(0, 1) ? FIT_MAX + $urandom_range(0, 2) - 1
                                  : -FIT_MAX + $urandom_range(0, 2) - 1;
      default: m = $signed(64'({$urandom} & 32'h000f_ffff)) - 64'sd500000;
    endcase
    return m;
  endfunction

  // Most exponents stay near the usable range; some roam the whole byte.
  function automatic logic signed [7:0] rand_exponent();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return $signed(8'($urandom_range(0, 60))) - 8'sd30;
  endfunction

  task automatic add_op(logic [1:0] op, logic signed [63:0] am, logic signed [7:0] ae,
                        logic signed [63:0] bm, logic signed [7:0] be);
    in_item_t it;
    it.op = op;
    it.a_mantissa = am;
    it.a_exponent = ae;
    it.b_mantissa = bm;
    it.b_exponent = be;
    pending_ops.push_back(it);
  endtask

  // Driver: a new item is placed only when the lane is empty or the current
  // one was just taken, so valid and the payload hold until acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) items_sent <= items_sent + 1;
      if (pending_ops.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_data <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: ready is chosen each cycle, except during the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_off_done && phase == 0 && items_sent > 40) begin
      hold_off_done <= 1'b1;
      hold_off_left <= 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(1, 100) > recv_idle_pct;
    end
  end

  // Monitor: every accepted item is held up against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: mantissa %0d exponent %0d error %0d",
               out_data.result_mantissa, out_data.result_exponent, out_data.error);
        failures++;
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_data.result_mantissa !== exp_r.result_mantissa) begin
          $error("result_mantissa: expected %0d, got %0d",
                 exp_r.result_mantissa, out_data.result_mantissa);
          failures++;
        end
        if (out_data.result_exponent !== exp_r.result_exponent) begin
          $error("result_exponent: expected %0d, got %0d",
                 exp_r.result_exponent, out_data.result_exponent);
          failures++;
        end
        if (out_data.error !== exp_r.error) begin
          $error("error: expected %0d, got %0d", exp_r.error, out_data.error);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: field extremes, each operation, and every error path.
    add_op(OP_ADD, 64'sd15, 8'sd2, 64'sd3, -8'sd1);
    add_op(OP_SUB, 64'sd15, -8'sd1, 64'sd3, 8'sd2);
    add_op(OP_ADD, MANT_MAX, 8'sd0, 64'sd1, 8'sd0);           // wraps
    add_op(OP_SUB, MANT_MIN, 8'sd0, 64'sd1, 8'sd0);           // wraps
    add_op(OP_ADD, MANT_MAX, 8'sd127, 64'sd1, -8'sd128);      // no common exponent
    add_op(OP_ADD, 64'sd1, 8'sd60, 64'sd0, 8'sd60);           // stays within the exponent limit
    add_op(OP_ADD, 64'sd7, -8'sd100, 64'sd3, -8'sd100);       // strict underflow
    add_op(OP_ADD, 64'sd0, 8'sd0, 64'sd0, 8'sd0);
    add_op(OP_MUL, 64'sd25, 8'sd3, 64'sd4, -8'sd1);
    add_op(OP_MUL, MANT_MAX, 8'sd0, MANT_MAX, 8'sd0);
    add_op(OP_MUL, 64'sd1, 8'sd40, 64'sd1, 8'sd30);           // exponent over
    add_op(OP_MUL, 64'sd1, -8'sd40, 64'sd1, -8'sd30);         // exponent under
    add_op(OP_MUL, MANT_MIN, 8'sd127, MANT_MIN, -8'sd128);
    add_op(OP_DIV, 64'sd1, 8'sd0, 64'sd3, 8'sd0);
    add_op(OP_DIV, 64'sd5, 8'sd0, 64'sd0, 8'sd0);             // divide by zero
    add_op(OP_DIV, MANT_MIN, -8'sd128, -64'sd1, 8'sd0);       // minimum over minus one
    add_op(OP_DIV, 64'sd0, 8'sd3, 64'sd7, 8'sd2);             // zero dividend
    add_op(OP_DIV, 64'sd1, 8'sd127, 64'sd1, -8'sd128);        // exponent range
    add_op(OP_DIV, 64'sd1, -8'sd128, 64'sd1, 8'sd127);
    add_op(OP_DIV, MANT_MAX, 8'sd100, 64'sd1, 8'sd0);         // lenient rescale fails
    add_op(OP_DIV, 64'sd1, -8'sd120, 64'sd7, 8'sd0);          // lenient underflow
    add_op(OP_DIV, MANT_MIN, 8'sd0, MANT_MAX, 8'sd0);
    foreach (pending_ops[i]) expected_results.push_back(decimal_result(pending_ops[i]));

    for (int p = 0; p < 3; p++) begin
      phase = p;
      send_idle_pct = (p == 0) ? 36 : (p == 1) ? 54 : 0;
      recv_idle_pct = (p == 0) ? 54 : (p == 1) ? 36 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        in_item_t it;
        it.op = 2'($urandom_range(0, 3));
        it.a_mantissa = rand_mantissa();
        it.a_exponent = rand_exponent();
        it.b_mantissa = ($urandom_range(0, 19) == 0) ? 64'sd0 : rand_mantissa();
        it.b_exponent = rand_exponent();
        expected_results.push_back(decimal_result(it));
        pending_ops.push_back(it);
      end
      while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    end

    while (expected_results.size() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
